FILE: rtl/nbc_pkg.sv
// ----------------------------------------------------------------------------
// nbc_pkg - shared types and constants of the 3x3 neighbour count block
// Holds the request and response payload structs, the line store entry
// layout and the register map constants of the configuration port.
// ----------------------------------------------------------------------------
package nbc_pkg;

   // Column counters and the row width register are six bits wide.
   localparam int COL_W = 6;
   // A 3x3 window sum is 0 to 9, a single column of the window is 0 to 3.
   localparam int SUM_W  = 4;
   localparam int VSUM_W = 2;

   // Configuration port.
   localparam int                  CSR_ADDR_W        = 3;
   localparam int                  CSR_DATA_W        = 32;
   localparam logic                CSR_IDX_ROW_WIDTH = 1'b0;
   localparam logic [COL_W-1:0]    ROW_WIDTH_RESET   = 6'd1;

   typedef struct packed {
      logic cell_bit;
      logic last_in_frame;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] neighbour_sum;
      logic             row_end;
      logic             frame_end;
   } rsp_type;

   // One line store entry holds a column of the two rows above the arriving row.
   typedef struct packed {
      logic upper;
      logic middle;
   } line_entry_type;

endpackage

FILE: rtl/nbc_line_mem.sv
// ----------------------------------------------------------------------------
// nbc_line_mem - line store of the neighbour count block
// Single write port, single read port, read data registered. A read of the
// entry written at the same edge returns the new data.
// ----------------------------------------------------------------------------
module nbc_line_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  nbc_pkg::line_entry_type        wr_data,
   input  logic [ADDR_W-1:0]              rd_addr,
   output nbc_pkg::line_entry_type        rd_data
);

   nbc_pkg::line_entry_type line_mem_ff [DEPTH];
   nbc_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/nbc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// nbc_rsp_fifo - two entry response queue
// Decouples the result channel from the request side so that a new request
// can be taken while a finished result still waits at the output.
// ----------------------------------------------------------------------------
module nbc_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  nbc_pkg::rsp_type  push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nbc_pkg::rsp_type  rsp_payload
);

   nbc_pkg::rsp_type slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full        = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/binary_grid_3x3_neighbour_count.sv
// ----------------------------------------------------------------------------
// binary_grid_3x3_neighbour_count - 3x3 box sum over a streamed binary grid
// Throughput: one request per cycle inside a row while the response queue has
// room; from the second row on, each row end takes no request during its upper
// sweep, and a frame end takes none during its flush of the remaining results.
// A cell's result enters the response queue when the request below and to its
// right is accepted; results closed by a row or frame end follow in the flush.
// Reset (synchronous, active high) empties the pipeline and sets row_width 1.
// ----------------------------------------------------------------------------
//
// The two rows above the arriving row live in one line store memory, one
// entry per column holding {upper, middle}. When a cell of the arriving row
// is accepted, the entry of its column (prefetched in the cycle before) is read,
// the column sum upper + middle + cell is formed, and the entry is written
// back rotated as {middle, cell}. That in-place rotation is what moves the
// rows down by one at the end of each row.
//
// Entries are never cleared. A rows seen counter says how many rows of the
// current frame have completed, and the upper and middle bits read from the
// store are masked to zero while they do not yet belong to this frame.
//
// Two registers hold the column sums of the previous two columns, so after the
// first row each accepted cell past column zero completes the window to its left.
//
// Row ends and frame ends are handled by a small sweep sequencer that reuses
// the same two window registers:
//  - The upper sweep finishes the row whose results are pending, walking the
//    columns to the right of the last cell and reading the store for each.
//    At an ordinary row end this is a single step for the last column.
//  - The lower sweep, at a frame end only, walks the final row again from
//    column zero, where the store now holds {middle, last row} for the cells
//    that arrived, and emits the results of the last row with the row below
//    counted as empty.
// The memory read address always follows the column that the next cycle will
// work on; a read of the entry written at the same edge is forwarded.
//
// Results go through a two entry queue, so a request can be taken while an
// earlier result still waits at the output.
// ----------------------------------------------------------------------------
module binary_grid_3x3_neighbour_count #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  nbc_pkg::req_type                      req_payload,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output nbc_pkg::rsp_type                      rsp_payload,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [nbc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [nbc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [nbc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int COL_W  = nbc_pkg::COL_W;
   localparam int SUM_W  = nbc_pkg::SUM_W;
   localparam int VSUM_W = nbc_pkg::VSUM_W;
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   localparam logic [COL_W-1:0] MAX_COLS = COL_W'(MAX_WIDTH);

   // Sequencer states.
   localparam logic [1:0] ST_STREAM = 2'd0;
   localparam logic [1:0] ST_UPPER  = 2'd1;
   localparam logic [1:0] ST_LOWER  = 2'd2;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [COL_W-1:0]  row_width_ff;
   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [COL_W-1:0]  column_pos_ff;
   logic [COL_W-1:0]  column_pos_in;
   logic [1:0]        rows_seen_ff;
   logic [1:0]        rows_seen_in;
   logic [COL_W-1:0]  sweep_col_ff;
   logic [COL_W-1:0]  sweep_col_in;
   logic [COL_W-1:0]  last_col_ff;
   logic [COL_W-1:0]  last_col_in;
   logic              flush_ff;
   logic              flush_in;
   logic [VSUM_W-1:0] win2_ff;
   logic [VSUM_W-1:0] win2_in;
   logic [VSUM_W-1:0] win1_ff;
   logic [VSUM_W-1:0] win1_in;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   logic csr_idx;
   logic cfg_write;

   assign csr_idx    = csr_paddr[nbc_pkg::CSR_ADDR_W-1];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_idx == nbc_pkg::CSR_IDX_ROW_WIDTH);
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == nbc_pkg::CSR_IDX_ROW_WIDTH) begin
         csr_prdata = {{(nbc_pkg::CSR_DATA_W-COL_W){1'b0}}, row_width_ff};
      end
   end

   // A width of zero acts as one, a width above the store depth as the depth.
   logic [COL_W-1:0] width_eff;

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (row_width_ff > MAX_COLS) begin
         width_eff = MAX_COLS;
      end else begin
         width_eff = row_width_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Line store
   // ------------------------------------------------------------------------
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wr_addr;
   nbc_pkg::line_entry_type mem_wr_data;
   logic [ADDR_W-1:0]       mem_rd_addr;
   nbc_pkg::line_entry_type rd_entry;

   nbc_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_entry)
   );

   // The upper row belongs to this frame once two rows have completed, the
   // middle row once one has.
   logic upper_ok;
   logic middle_ok;
   logic up_v;
   logic mid_v;

   assign upper_ok  = (rows_seen_ff >= 2'd2);
   assign middle_ok = (rows_seen_ff != 2'd0);
   assign up_v      = rd_entry.upper & upper_ok;
   assign mid_v     = rd_entry.middle & middle_ok;

   // ------------------------------------------------------------------------
   // Column sum of the column the sequencer is on, and the window sum
   // ------------------------------------------------------------------------
   logic              accept;
   logic              at_row_end;
   logic [VSUM_W-1:0] col_sum;
   logic [SUM_W-1:0]  win_sum;

   assign accept     = req_valid && req_ready;
   assign at_row_end = (column_pos_ff == (width_eff - COL_W'(1)))
                       || req_payload.last_in_frame;

   always_comb begin
      col_sum = '0;
      case (state_ff)
         ST_STREAM: begin
            col_sum = {1'b0, up_v} + {1'b0, mid_v} + {1'b0, req_payload.cell_bit};
         end
         ST_UPPER: begin
            // Past the last arrived cell the arriving row counts as empty.
            if (sweep_col_ff < width_eff) begin
               col_sum = {1'b0, up_v} + {1'b0, mid_v};
            end
         end
         ST_LOWER: begin
            // Columns up to the last cell were rotated when that cell came
            // in; the column just right of it still holds the old rows.
            if (sweep_col_ff >= width_eff) begin
               col_sum = '0;
            end else if (sweep_col_ff <= last_col_ff) begin
               col_sum = {1'b0, rd_entry.upper} + {1'b0, rd_entry.middle};
            end else begin
               col_sum = {1'b0, mid_v};
            end
         end
         default: begin
            col_sum = '0;
         end
      endcase
   end

   assign win_sum = {2'b00, win2_ff} + {2'b00, win1_ff} + {2'b00, col_sum};

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   logic             fifo_full;
   logic             push_valid;
   nbc_pkg::rsp_type push_data;

   assign req_ready = (state_ff == ST_STREAM) && !fifo_full;

   always_comb begin
      state_in      = state_ff;
      column_pos_in = column_pos_ff;
      rows_seen_in  = rows_seen_ff;
      sweep_col_in  = sweep_col_ff;
      last_col_in   = last_col_ff;
      flush_in      = flush_ff;
      win2_in       = win2_ff;
      win1_in       = win1_ff;

      mem_we             = 1'b0;
      mem_wr_addr        = column_pos_ff[ADDR_W-1:0];
      mem_wr_data.upper  = mid_v;
      mem_wr_data.middle = req_payload.cell_bit;

      push_valid              = 1'b0;
      push_data.neighbour_sum = win_sum;
      push_data.row_end       = 1'b0;
      push_data.frame_end     = 1'b0;

      case (state_ff)
         ST_STREAM: begin
            if (accept) begin
               mem_we = 1'b1;
               // Past row and column zero, a cell closes the window to its left.
               push_valid = middle_ok && (column_pos_ff != '0);
               win2_in    = (column_pos_ff == '0) ? '0 : win1_ff;
               win1_in    = col_sum;
               last_col_in = column_pos_ff;
               flush_in    = req_payload.last_in_frame;
               column_pos_in = column_pos_ff + COL_W'(1);
               if (at_row_end) begin
                  column_pos_in = '0;
                  if (!req_payload.last_in_frame) begin
                     rows_seen_in = (rows_seen_ff == 2'd3) ? 2'd3
                                                           : rows_seen_ff + 2'd1;
                  end
                  if (middle_ok) begin
                     state_in     = ST_UPPER;
                     sweep_col_in = column_pos_ff + COL_W'(1);
                  end else if (req_payload.last_in_frame) begin
                     // A single row frame: only the last row is left to send.
                     state_in     = ST_LOWER;
                     sweep_col_in = '0;
                     win2_in      = '0;
                     win1_in      = '0;
                  end
               end
            end
         end
         ST_UPPER: begin
            if (!fifo_full) begin
               push_valid        = 1'b1;
               push_data.row_end = (sweep_col_ff == width_eff);
               win2_in      = win1_ff;
               win1_in      = col_sum;
               sweep_col_in = sweep_col_ff + COL_W'(1);
               if (sweep_col_ff == width_eff) begin
                  if (flush_ff) begin
                     state_in     = ST_LOWER;
                     sweep_col_in = '0;
                     win2_in      = '0;
                     win1_in      = '0;
                  end else begin
                     state_in = ST_STREAM;
                  end
               end
            end
         end
         ST_LOWER: begin
            if (!fifo_full) begin
               // The first step only primes the window with column zero.
               push_valid          = (sweep_col_ff != '0);
               push_data.row_end   = (sweep_col_ff == last_col_ff + COL_W'(1));
               push_data.frame_end = (sweep_col_ff == last_col_ff + COL_W'(1));
               win2_in      = win1_ff;
               win1_in      = col_sum;
               sweep_col_in = sweep_col_ff + COL_W'(1);
               if (sweep_col_ff == last_col_ff + COL_W'(1)) begin
                  state_in      = ST_STREAM;
                  rows_seen_in  = 2'd0;
                  column_pos_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_STREAM;
         end
      endcase

      // A new row width starts a fresh frame.
      if (cfg_write) begin
         state_in      = ST_STREAM;
         column_pos_in = '0;
         rows_seen_in  = 2'd0;
      end

      // Prefetch the entry of the column that the next cycle works on.
      if (state_in == ST_STREAM) begin
         mem_rd_addr = column_pos_in[ADDR_W-1:0];
      end else begin
         mem_rd_addr = sweep_col_in[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= nbc_pkg::ROW_WIDTH_RESET;
         state_ff      <= ST_STREAM;
         column_pos_ff <= '0;
         rows_seen_ff  <= 2'd0;
         flush_ff      <= 1'b0;
      end else begin
         if (cfg_write) begin
            row_width_ff <= csr_pwdata[COL_W-1:0];
         end
         state_ff      <= state_in;
         column_pos_ff <= column_pos_in;
         rows_seen_ff  <= rows_seen_in;
         flush_ff      <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_col_ff <= sweep_col_in;
      last_col_ff  <= last_col_in;
      win2_ff      <= win2_in;
      win1_ff      <= win1_in;
   end

   // ------------------------------------------------------------------------
   // Response queue
   // ------------------------------------------------------------------------
   nbc_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .full        (fifo_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: dv/binary_grid_3x3_neighbour_count_tb.sv
// ----------------------------------------------------------------------------
// binary_grid_3x3_neighbour_count_tb - self-checking bench for the 3x3 box sum
// Streams binary grids into the block one cell per request and rebuilds every
// expected window sum in a scoreboard that keeps its own three rows. Each
// response is checked field by field against the oldest expected result.
// Random idling on both channels, a long response hold-off, and row width
// changes between phases exercise the flush, the restart and the stall paths.
// ----------------------------------------------------------------------------
module binary_grid_3x3_neighbour_count_tb;

   localparam int COL_W        = nbc_pkg::COL_W;
   localparam int SUM_W        = nbc_pkg::SUM_W;
   localparam int CSR_ADDR_W   = nbc_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = nbc_pkg::CSR_DATA_W;
   localparam int GRID_MAX     = 32;
   localparam int CYCLE_LIMIT  = 500000;
   // A frame end flush may run with no response owed beforehand; this settle
   // time is meant to let the block go quiet.
   localparam int SETTLE_CYCLES = 2 * GRID_MAX + 8;
   localparam int LONG_HOLD     = 150;
   localparam int RANDOM_ITEMS  = 70;
   localparam logic [CSR_ADDR_W-1:0] ROW_WIDTH_ADDR =
      CSR_ADDR_W'(4 * int'(nbc_pkg::CSR_IDX_ROW_WIDTH));

   // The scoreboard mirrors the block: three rows of the grid, the column of
   // the next cell and the number of completed rows in the frame. Every
   // request appends the window sums it completes to a queue of owed sums.
   class grid_sum_scoreboard;
      logic [COL_W-1:0]  width_reg;
      bit [GRID_MAX-1:0] upper_row;
      bit [GRID_MAX-1:0] middle_row;
      bit [GRID_MAX-1:0] lower_row;
      int unsigned       col_next;
      int unsigned       rows_done;
      nbc_pkg::rsp_type  owed_sums[$];
      int                mismatches;

      function new();
         width_reg  = nbc_pkg::ROW_WIDTH_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         upper_row  = '0;
         middle_row = '0;
         lower_row  = '0;
         col_next   = 0;
         rows_done  = 0;
      endfunction

      // A row width write restarts the frame and drops anything pending.
      function void set_row_width(logic [COL_W-1:0] value);
         width_reg = value;
         owed_sums.delete();
         restart();
      endfunction

      // Zero behaves as one column, anything above the store size as full size.
      function int unsigned active_width();
         if (width_reg == 0) begin
            return 1;
         end
         if (width_reg > GRID_MAX) begin
            return GRID_MAX;
         end
         return width_reg;
      endfunction

      function logic [SUM_W-1:0] box_sum(bit [GRID_MAX-1:0] above,
                                         bit [GRID_MAX-1:0] centre,
                                         bit [GRID_MAX-1:0] below,
                                         int unsigned col, int unsigned w);
         int unsigned lo;
         int unsigned hi;
         int unsigned total;
         lo    = (col > 0) ? col - 1 : 0;
         hi    = (col + 1 < w) ? col + 1 : w - 1;
         total = 0;
         for (int unsigned k = lo; k <= hi; k++) begin
            total += int'(above[k]) + int'(centre[k]) + int'(below[k]);
         end
         return SUM_W'(total);
      endfunction

      function void owe(logic [SUM_W-1:0] sum, bit at_row_end, bit at_frame_end);
         nbc_pkg::rsp_type entry;
         entry.neighbour_sum = sum;
         entry.row_end       = at_row_end;
         entry.frame_end     = at_frame_end;
         owed_sums.push_back(entry);
      endfunction

      function void note_request(nbc_pkg::req_type item);
         int unsigned w;
         int unsigned c;
         bit          closes_row;
         w = active_width();
         c = col_next;
         if (c >= w) begin
            c = 0;
         end
         lower_row[c] = item.cell_bit;
         closes_row   = (c == w - 1) || item.last_in_frame;

         // Once a row is complete, each new cell past column zero finishes the
         // window to its left, and a row end finishes the rest of that row.
         if (rows_done >= 1) begin
            if (c >= 1) begin
               owe(box_sum(upper_row, middle_row, lower_row, c - 1, w), 1'b0, 1'b0);
            end
            if (closes_row) begin
               for (int unsigned j = c; j < w; j++) begin
                  owe(box_sum(upper_row, middle_row, lower_row, j, w), j == w - 1, 1'b0);
               end
            end
         end

         if (item.last_in_frame) begin
            // The final row sees an empty row below it; only the cells that
            // arrived get results, the last one closing row and frame.
            for (int unsigned j = 0; j <= c; j++) begin
               owe(box_sum(middle_row, lower_row, '0, j, w), j == c, j == c);
            end
            restart();
         end else if (closes_row) begin
            upper_row  = middle_row;
            middle_row = lower_row;
            lower_row  = '0;
            if (rows_done < 3) begin
               rows_done++;
            end
            col_next = 0;
         end else begin
            col_next = c + 1;
         end
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 50) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      function void check_response(nbc_pkg::rsp_type got);
         nbc_pkg::rsp_type want;
         if (owed_sums.size() == 0) begin
            report($sformatf("response sum=%0d row_end=%0d frame_end=%0d with none owed",
                             got.neighbour_sum, got.row_end, got.frame_end));
            return;
         end
         want = owed_sums.pop_front();
         if (got.neighbour_sum !== want.neighbour_sum) begin
            report($sformatf("neighbour_sum got %0d want %0d",
                             got.neighbour_sum, want.neighbour_sum));
         end
         if (got.row_end !== want.row_end) begin
            report($sformatf("row_end got %0d want %0d", got.row_end, want.row_end));
         end
         if (got.frame_end !== want.frame_end) begin
            report($sformatf("frame_end got %0d want %0d", got.frame_end, want.frame_end));
         end
      endfunction

      function int pending();
         return owed_sums.size();
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   nbc_pkg::req_type      req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   nbc_pkg::rsp_type      rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grid_sum_scoreboard sums;
   // steady_mode turns idling off on both sides; hold_request asks the
   // response side for one long hold-off.
   bit          steady_mode  = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned stall_left   = 0;
   int unsigned ready_gap;
   int unsigned cycle_count  = 0;

   always #5 clock = ~clock;

   binary_grid_3x3_neighbour_count #(
      .MAX_WIDTH(GRID_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Idle gaps: mostly none, often short ones, now and then a long one.
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Both channels are sampled at the rising edge, before the nonblocking
   // updates of that edge land, so the view matches what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sums.note_request(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            sums.check_response(rsp_payload);
         end
      end
   end

   // Response side: random stalls, plus one long hold-off counted here so the
   // block's output queue fills and it stops taking requests.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left   = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (steady_mode) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_gap = idle_gap();
         if (ready_gap == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = ready_gap - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // Watchdog for a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offers one request and holds it until accepted. Valid is only lowered
   // when a gap follows, so back-to-back requests keep it high.
   task automatic send_cell(input logic cell_value, input logic last);
      nbc_pkg::req_type item;
      int unsigned      gap;
      item.cell_bit      = cell_value;
      item.last_in_frame = last;
      req_payload <= item;
      req_valid   <= 1'b1;
      do begin
         @(posedge clock);
      end while (!(req_valid === 1'b1 && req_ready === 1'b1));
      gap = steady_mode ? 0 : idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every owed sum has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sums.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // The row width is only changed with the block idle. Requests that owe no
   // result may still be in flight, so a settle time follows the drain.
   task automatic write_row_width(input logic [COL_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROW_WIDTH_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sums.set_row_width(value);
   endtask

   // One frame of random cells. density is in quarters: 0 gives an empty
   // grid and 4 a full one. A noisy frame may end early at random.
   task automatic send_frame(input int unsigned cells, input int unsigned density,
                             input bit noisy);
      logic cell_value;
      logic last;
      for (int unsigned i = 0; i < cells; i++) begin
         cell_value = ($urandom_range(0, 3) < density);
         last = (i == cells - 1) || (noisy && $urandom_range(0, 15) == 0);
         send_cell(cell_value, last);
         if ($urandom_range(0, 49) == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin
      int unsigned      random_sent;
      int unsigned      phase_sent;
      int unsigned      phase_no;
      int unsigned      budget;
      int unsigned      rows;
      int unsigned      cells;
      int unsigned      w;
      int unsigned      r;
      logic [COL_W-1:0] width_code;

      sums = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The reset width of one column comes first: a single
      // column grid has no left or right neighbours.
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b1);

      // A width of zero behaves as one column.
      write_row_width('0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);

      // A full 3x3 grid reaches the largest sum in its centre.
      write_row_width(COL_W'(3));
      for (int i = 0; i < 9; i++) begin
         send_cell(1'b1, i == 8);
      end

      // The frame ends one cell into its second row.
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);

      // A frame left unfinished is dropped by the next width write.
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);

      // The largest code clamps to the full store width: a one-cell frame,
      // then a single short row that is flushed by its last cell.
      write_row_width('1);
      send_cell(1'b1, 1'b1);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b1);

      // Random part: phases of one row width each, mostly narrow grids, with
      // well-formed frames and now and then an early frame end. The second
      // phase always runs, since it carries the long hold-off.
      random_sent = 0;
      phase_no    = 0;
      while (random_sent < RANDOM_ITEMS || phase_no < 2) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            width_code = COL_W'(GRID_MAX);
         end else if (r < 14) begin
            width_code = COL_W'($urandom_range(GRID_MAX + 1, 63));
         end else if (r < 18) begin
            width_code = '0;
         end else begin
            width_code = COL_W'($urandom_range(1, 8));
         end
         // The second phase backs up the output: the response side holds off
         // for a long stretch while requests keep coming without gaps.
         if (phase_no == 1) begin
            width_code = COL_W'(3);
         end
         write_row_width(width_code);
         w = sums.active_width();

         budget      = (w > 8) ? 30 : $urandom_range(15, 30);
         steady_mode = (phase_no == 1) || ($urandom_range(0, 3) == 0);
         if (phase_no == 1) begin
            hold_request = 1'b1;
         end

         phase_sent = 0;
         while (phase_sent < budget) begin
            rows  = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
            cells = rows * w;
            if (w > 1 && $urandom_range(0, 4) == 0) begin
               cells -= $urandom_range(1, w - 1);
            end
            send_frame(cells, $urandom_range(0, 4), $urandom_range(0, 9) == 0);
            phase_sent += cells;
            // In the first phase the sender always waits for the results of
            // a frame before the next one; later only sometimes.
            if (phase_no == 0 || $urandom_range(0, 3) == 0) begin
               wait_drained();
            end
         end
         random_sent += phase_sent;
         steady_mode  = 1'b0;
         phase_no++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sums.pending() == 0 && sums.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/nbc_pkg.sv
rtl/nbc_line_mem.sv
rtl/nbc_rsp_fifo.sv
rtl/binary_grid_3x3_neighbour_count.sv
dv/binary_grid_3x3_neighbour_count_tb.sv
